### src/tti_pkg.sv
`default_nettype none

package tti_pkg;

  localparam int unsigned ROWS       = 8;
  localparam int unsigned POINTS     = 32;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned ROW_W      = $clog2(ROWS);
  localparam int unsigned PT_W       = $clog2(POINTS);
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned ROWS_CFG_W = 4;
  localparam int unsigned PTS_CFG_W  = 6;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned APB_W      = 32;

  // Q0.16 weights, full weight 1.0 needs one more bit
  localparam int unsigned W_BITS     = 16;
  localparam int unsigned WT_W       = W_BITS + 1;
  localparam int unsigned PROD_W     = WT_W + DATA_W;

  // quotient bits resolved per divider stage
  localparam int unsigned DIV_BITS   = 4;
  localparam int unsigned DIV_STAGES = W_BITS / DIV_BITS;

  // memories are split by row parity (and point parity for mobility)
  localparam int unsigned ROW_PAIRS  = ROWS / 2;
  localparam int unsigned PAIR_W     = $clog2(ROW_PAIRS);
  localparam int unsigned MOB_DEPTH  = ROWS * POINTS / 4;
  localparam int unsigned MOB_AW     = $clog2(MOB_DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_ROW   = 2'd0,
    CMD_LOAD_POINT = 2'd1,
    CMD_QUERY      = 2'd2
  } cmd_e;

  // register index is bit 2 of the byte address
  localparam logic REG_ROWS   = 1'b0;
  localparam logic REG_POINTS = 1'b1;

  typedef logic [DATA_W-1:0]              word_t;
  typedef logic [ROW_W-1:0]               row_t;
  typedef logic [PT_W-1:0]                pt_t;
  typedef logic [PAIR_W-1:0]              pair_t;
  typedef logic [MOB_AW-1:0]              mob_addr_t;
  typedef logic [WT_W-1:0]                wt_t;
  typedef logic [W_BITS-1:0]              quo_t;
  typedef logic [PROD_W-1:0]              prod_t;
  typedef logic [POINTS-1:0][DATA_W-1:0]  erow_t;

  localparam wt_t W_ONE = {1'b1, {W_BITS{1'b0}}};

  typedef struct packed {
    word_t rem;
    word_t den;
    quo_t  quo;
  } div_t;

  // restoring division, DIV_BITS quotient bits; rem stays below den
  function automatic div_t div_step(div_t s);
    div_t                 r;
    logic [DATA_W+1:0]    t;
    r = s;
    for (int k = 0; k < DIV_BITS; k++) begin
      t = {1'b0, r.rem, 1'b0} - {2'b00, r.den};
      if (!t[DATA_W+1]) begin
        r.rem = t[DATA_W-1:0];
        r.quo = {r.quo[W_BITS-2:0], 1'b1};
      end else begin
        r.rem = {r.rem[DATA_W-2:0], 1'b0};
        r.quo = {r.quo[W_BITS-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/tti_intf.sv
`default_nettype none

interface tti_in_if;
  logic                        valid;
  logic                        ready;
  logic [tti_pkg::CMD_W-1:0]   cmd;
  logic [tti_pkg::ROW_W-1:0]   row_index;
  logic [tti_pkg::PT_W-1:0]    point_index;
  logic [tti_pkg::DATA_W-1:0]  axis_value;
  logic [tti_pkg::DATA_W-1:0]  energy_value;
  logic [tti_pkg::DATA_W-1:0]  mobility_value;

  modport source (
    output valid, cmd, row_index, point_index, axis_value, energy_value, mobility_value,
    input  ready
  );
  modport sink (
    input  valid, cmd, row_index, point_index, axis_value, energy_value, mobility_value,
    output ready
  );
endinterface

interface tti_out_if;
  logic                        valid;
  logic                        ready;
  logic [tti_pkg::DATA_W-1:0]  mobility_out;
  logic                        axis_clamped;
  logic                        energy_clamped;

  modport source (
    output valid, mobility_out, axis_clamped, energy_clamped,
    input  ready
  );
  modport sink (
    input  valid, mobility_out, axis_clamped, energy_clamped,
    output ready
  );
endinterface

`default_nettype wire

### src/tti_divider.sv
`default_nettype none

// (num << 16) / den, pipelined; each stage resolves DIV_BITS quotient bits
module tti_divider (
  input  logic                clk_i,
  input  logic                en_i,
  input  tti_pkg::word_t      num_i,
  input  tti_pkg::word_t      den_i,
  output tti_pkg::quo_t       quo_o
);

  tti_pkg::div_t st_q [tti_pkg::DIV_STAGES];
  tti_pkg::div_t st_in;

  always_comb begin
    st_in.rem = num_i;
    st_in.den = den_i;
    st_in.quo = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= tti_pkg::div_step(st_in);
      for (int k = 1; k < tti_pkg::DIV_STAGES; k++) begin
        st_q[k] <= tti_pkg::div_step(st_q[k-1]);
      end
    end
  end

  assign quo_o = st_q[tti_pkg::DIV_STAGES-1].quo;

endmodule

`default_nettype wire

### src/tti_point_bracket.sv
`default_nettype none

// brackets x within one row of energies; lower end tested first
module tti_point_bracket (
  input  tti_pkg::erow_t  row_i,
  input  tti_pkg::pt_t    last_i,
  input  tti_pkg::word_t  x_i,
  output tti_pkg::pt_t    lo_o,
  output tti_pkg::pt_t    hi_o,
  output logic            clamped_o,
  output tti_pkg::word_t  e_lo_o,
  output tti_pkg::word_t  e_hi_o
);

  tti_pkg::pt_t inner;

  always_comb begin
    inner = '0;
    for (int i = 1; i < tti_pkg::POINTS - 1; i++) begin
      if (tti_pkg::pt_t'(i) < last_i && row_i[i] <= x_i) begin
        inner = tti_pkg::pt_t'(i);
      end
    end
    if (x_i <= row_i[0]) begin
      lo_o      = '0;
      hi_o      = '0;
      clamped_o = x_i < row_i[0];
    end else if (x_i >= row_i[last_i]) begin
      lo_o      = last_i;
      hi_o      = last_i;
      clamped_o = x_i > row_i[last_i];
    end else begin
      lo_o      = inner;
      hi_o      = inner + tti_pkg::pt_t'(1);
      clamped_o = 1'b0;
    end
  end

  assign e_lo_o = row_i[lo_o];
  assign e_hi_o = row_i[hi_o];

endmodule

`default_nettype wire

### src/two_level_table_interpolator.sv
`default_nettype none

// Two-level table interpolator. Loads (row axis values, energy/mobility points) and queries
// share one input stream and pass through one pipeline in order, so every load is seen by all
// items that follow it. A new item is taken every cycle while the output is not stalled; a query
// passes the registered bracket and memory stages, the four-stage weight dividers and the two
// multiply/add blend stages. A stalled output freezes the whole pipeline, input included. Table
// entries come up undefined after reset and must be loaded before a query reads them; there is
// no clearing pass. The user writes rows_in_use (address 0) and points_in_use (address 4) via the
// APB port only while the block is idle (not enforced); zero counts act as one, large ones clamp.
module two_level_table_interpolator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tti_in_if.sink                        in_i,
  tti_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tti_pkg::PADDR_W-1:0]   paddr,
  input  logic [tti_pkg::APB_W-1:0]     pwdata,
  output logic [tti_pkg::APB_W-1:0]     prdata,
  output logic                          pready
);

  typedef struct packed {
    logic [tti_pkg::CMD_W-1:0] cmd;
    tti_pkg::row_t             ri;
    tti_pkg::pt_t              pi;
    tti_pkg::word_t            ax;
    tti_pkg::word_t            en;
    tti_pkg::word_t            mo;
  } item_t;

  typedef struct packed {
    item_t          it;
    tti_pkg::row_t  r0;
    tti_pkg::row_t  r1;
    logic           ac;
    tti_pkg::word_t ra_lo;
    tti_pkg::word_t ra_hi;
  } s2_t;

  typedef struct packed {
    item_t          it;
    tti_pkg::row_t  r0;
    tti_pkg::row_t  r1;
    logic           ac;
    tti_pkg::word_t rdx;
    tti_pkg::word_t rden;
  } s3_t;

  typedef struct packed {
    item_t          it;
    tti_pkg::row_t  r0;
    tti_pkg::row_t  r1;
    logic           ac;
    logic           ec;
    tti_pkg::word_t rdx;
    tti_pkg::word_t rden;
    tti_pkg::pt_t   lo0;
    tti_pkg::pt_t   hi0;
    tti_pkg::pt_t   lo1;
    tti_pkg::pt_t   hi1;
    tti_pkg::word_t elo0;
    tti_pkg::word_t ehi0;
    tti_pkg::word_t elo1;
    tti_pkg::word_t ehi1;
  } s4_t;

  typedef struct packed {
    logic           ac;
    logic           ec;
    logic           rz;
    logic           ez0;
    logic           ez1;
    logic           same;
    logic           r0p;
    logic           lo0p;
    logic           hi0p;
    logic           lo1p;
    logic           hi1p;
    tti_pkg::word_t rdx;
    tti_pkg::word_t rden;
    tti_pkg::word_t edx0;
    tti_pkg::word_t eden0;
    tti_pkg::word_t edx1;
    tti_pkg::word_t eden1;
  } s5_t;

  typedef struct packed {
    logic           ac;
    logic           ec;
    logic           rz;
    logic           ez0;
    logic           ez1;
    tti_pkg::word_t ml0;
    tti_pkg::word_t mh0;
    tti_pkg::word_t ml1;
    tti_pkg::word_t mh1;
  } tail_t;

  typedef struct packed {
    logic           ac;
    logic           ec;
    tti_pkg::wt_t   wr;
    tti_pkg::prod_t pa0;
    tti_pkg::prod_t pb0;
    tti_pkg::prod_t pa1;
    tti_pkg::prod_t pb1;
  } s6_t;

  typedef struct packed {
    logic           ac;
    logic           ec;
    tti_pkg::wt_t   wr;
    tti_pkg::word_t mu0;
    tti_pkg::word_t mu1;
  } s7_t;

  typedef struct packed {
    logic           ac;
    logic           ec;
    tti_pkg::prod_t pr0;
    tti_pkg::prod_t pr1;
  } s8_t;

  logic adv;
  logic out_valid_q;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // ---------------- configuration ----------------
  logic [tti_pkg::ROWS_CFG_W-1:0] rows_q;
  logic [tti_pkg::PTS_CFG_W-1:0]  pts_q;
  tti_pkg::row_t                  row_last;
  tti_pkg::pt_t                   pt_last;
  logic                           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= tti_pkg::ROWS_CFG_W'(1);
      pts_q  <= tti_pkg::PTS_CFG_W'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == tti_pkg::REG_ROWS) begin
        rows_q <= pwdata[tti_pkg::ROWS_CFG_W-1:0];
      end else begin
        pts_q <= pwdata[tti_pkg::PTS_CFG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == tti_pkg::REG_POINTS) ? tti_pkg::APB_W'(pts_q)
                                                    : tti_pkg::APB_W'(rows_q);

  always_comb begin
    if (rows_q == '0) begin
      row_last = '0;
    end else if (rows_q > tti_pkg::ROWS_CFG_W'(tti_pkg::ROWS)) begin
      row_last = tti_pkg::row_t'(tti_pkg::ROWS - 1);
    end else begin
      row_last = tti_pkg::row_t'(rows_q - tti_pkg::ROWS_CFG_W'(1));
    end
    if (pts_q == '0) begin
      pt_last = '0;
    end else if (pts_q > tti_pkg::PTS_CFG_W'(tti_pkg::POINTS)) begin
      pt_last = tti_pkg::pt_t'(tti_pkg::POINTS - 1);
    end else begin
      pt_last = tti_pkg::pt_t'(pts_q - tti_pkg::PTS_CFG_W'(1));
    end
  end

  // ---------------- pipeline registers ----------------
  item_t  it1_q;
  s2_t    s2_q;
  s3_t    s3_q;
  s4_t    s4_q;
  s5_t    s5_q;
  tail_t  tail_q [tti_pkg::DIV_STAGES];
  s6_t    s6_q;
  s7_t    s7_q;
  s8_t    s8_q;
  logic   v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;
  logic   vd_q [tti_pkg::DIV_STAGES];

  tti_pkg::word_t mob_q;
  logic           ac_q;
  logic           ec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      v8_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < tti_pkg::DIV_STAGES; k++) begin
        vd_q[k] <= 1'b0;
      end
    end else if (adv) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      // only queries go on past the memory stages
      v5_q <= v4_q && (s4_q.it.cmd == tti_pkg::CMD_QUERY);
      vd_q[0] <= v5_q;
      for (int k = 1; k < tti_pkg::DIV_STAGES; k++) begin
        vd_q[k] <= vd_q[k-1];
      end
      v6_q        <= vd_q[tti_pkg::DIV_STAGES-1];
      v7_q        <= v6_q;
      v8_q        <= v7_q;
      out_valid_q <= v8_q;
    end
  end

  // ---------------- stage A: row bracket ----------------
  tti_pkg::word_t row_axis_q [tti_pkg::ROWS];
  tti_pkg::row_t  r0_a, r1_a, inner_a;
  logic           ac_a;

  always_ff @(posedge clk_i) begin
    if (adv && v1_q && it1_q.cmd == tti_pkg::CMD_LOAD_ROW) begin
      row_axis_q[it1_q.ri] <= it1_q.ax;
    end
  end

  always_comb begin
    inner_a = '0;
    for (int i = 1; i < tti_pkg::ROWS - 1; i++) begin
      if (tti_pkg::row_t'(i) < row_last && row_axis_q[i] <= it1_q.ax) begin
        inner_a = tti_pkg::row_t'(i);
      end
    end
    if (it1_q.ax <= row_axis_q[0]) begin
      r0_a = '0;
      r1_a = '0;
      ac_a = it1_q.ax < row_axis_q[0];
    end else if (it1_q.ax >= row_axis_q[row_last]) begin
      r0_a = row_last;
      r1_a = row_last;
      ac_a = it1_q.ax > row_axis_q[row_last];
    end else begin
      r0_a = inner_a;
      r1_a = inner_a + tti_pkg::row_t'(1);
      ac_a = 1'b0;
    end
  end

  // ---------------- stage B: energy row reads ----------------
  tti_pkg::erow_t erd_q [2];
  tti_pkg::pair_t eaddr [2];
  logic           epar_q;
  logic           esame_q;

  always_comb begin
    if (s2_q.r0[0]) begin
      eaddr[0] = s2_q.r1[tti_pkg::ROW_W-1:1];
      eaddr[1] = s2_q.r0[tti_pkg::ROW_W-1:1];
    end else begin
      eaddr[0] = s2_q.r0[tti_pkg::ROW_W-1:1];
      eaddr[1] = s2_q.r1[tti_pkg::ROW_W-1:1];
    end
  end

  for (genvar bp = 0; bp < 2; bp++) begin : gen_ebank
    tti_pkg::erow_t ebank [tti_pkg::ROW_PAIRS];
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (v2_q && s2_q.it.cmd == tti_pkg::CMD_LOAD_POINT && s2_q.it.ri[0] == 1'(bp)) begin
          ebank[s2_q.it.ri[tti_pkg::ROW_W-1:1]][s2_q.it.pi] <= s2_q.it.en;
        end
        erd_q[bp] <= ebank[eaddr[bp]];
      end
    end
  end

  // ---------------- stage C: energy brackets ----------------
  tti_pkg::erow_t erow0, erow1;
  tti_pkg::pt_t   lo0_c, hi0_c, lo1_c, hi1_c;
  logic           cl0_c, cl1_c;
  tti_pkg::word_t elo0_c, ehi0_c, elo1_c, ehi1_c;

  assign erow0 = epar_q ? erd_q[1] : erd_q[0];
  assign erow1 = esame_q ? erow0 : (epar_q ? erd_q[0] : erd_q[1]);

  tti_point_bracket u_bracket0 (
    .row_i     (erow0),
    .last_i    (pt_last),
    .x_i       (s3_q.it.en),
    .lo_o      (lo0_c),
    .hi_o      (hi0_c),
    .clamped_o (cl0_c),
    .e_lo_o    (elo0_c),
    .e_hi_o    (ehi0_c)
  );

  tti_point_bracket u_bracket1 (
    .row_i     (erow1),
    .last_i    (pt_last),
    .x_i       (s3_q.it.en),
    .lo_o      (lo1_c),
    .hi_o      (hi1_c),
    .clamped_o (cl1_c),
    .e_lo_o    (elo1_c),
    .e_hi_o    (ehi1_c)
  );

  // ---------------- stage D: mobility reads ----------------
  tti_pkg::word_t    mrd_q [2][2];
  tti_pkg::mob_addr_t maddr [2][2];

  always_comb begin
    tti_pkg::row_t r_sel;
    tti_pkg::pt_t  lo_sel, hi_sel, pt_sel;
    for (int rp = 0; rp < 2; rp++) begin
      for (int pp = 0; pp < 2; pp++) begin
        if (s4_q.r0[0] == rp[0]) begin
          r_sel  = s4_q.r0;
          lo_sel = s4_q.lo0;
          hi_sel = s4_q.hi0;
        end else begin
          r_sel  = s4_q.r1;
          lo_sel = s4_q.lo1;
          hi_sel = s4_q.hi1;
        end
        pt_sel = (lo_sel[0] == pp[0]) ? lo_sel : hi_sel;
        maddr[rp][pp] = {r_sel[tti_pkg::ROW_W-1:1], pt_sel[tti_pkg::PT_W-1:1]};
      end
    end
  end

  for (genvar rp = 0; rp < 2; rp++) begin : gen_mrow
    for (genvar pp = 0; pp < 2; pp++) begin : gen_mpt
      tti_pkg::word_t mbank [tti_pkg::MOB_DEPTH];
      always_ff @(posedge clk_i) begin
        if (adv) begin
          if (v4_q && s4_q.it.cmd == tti_pkg::CMD_LOAD_POINT &&
              s4_q.it.ri[0] == 1'(rp) && s4_q.it.pi[0] == 1'(pp)) begin
            mbank[{s4_q.it.ri[tti_pkg::ROW_W-1:1], s4_q.it.pi[tti_pkg::PT_W-1:1]}]
              <= s4_q.it.mo;
          end
          mrd_q[rp][pp] <= mbank[maddr[rp][pp]];
        end
      end
    end
  end

  // ---------------- stage E: pick mobilities, start division ----------------
  tail_t tail_e;

  always_comb begin
    tail_e.ac  = s5_q.ac;
    tail_e.ec  = s5_q.ec;
    tail_e.rz  = s5_q.rz;
    tail_e.ez0 = s5_q.ez0;
    tail_e.ez1 = s5_q.ez1;
    tail_e.ml0 = mrd_q[s5_q.r0p][s5_q.lo0p];
    tail_e.mh0 = mrd_q[s5_q.r0p][s5_q.hi0p];
    if (s5_q.same) begin
      tail_e.ml1 = tail_e.ml0;
      tail_e.mh1 = tail_e.mh0;
    end else begin
      tail_e.ml1 = mrd_q[!s5_q.r0p][s5_q.lo1p];
      tail_e.mh1 = mrd_q[!s5_q.r0p][s5_q.hi1p];
    end
  end

  tti_pkg::quo_t qr, q0, q1;

  tti_divider u_div_row (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (s5_q.rdx),
    .den_i (s5_q.rden),
    .quo_o (qr)
  );

  tti_divider u_div_e0 (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (s5_q.edx0),
    .den_i (s5_q.eden0),
    .quo_o (q0)
  );

  tti_divider u_div_e1 (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (s5_q.edx1),
    .den_i (s5_q.eden1),
    .quo_o (q1)
  );

  // ---------------- stage F: weights and point blend products ----------------
  tail_t        tl;
  tti_pkg::wt_t wr_f, w0_f, w1_f;

  assign tl   = tail_q[tti_pkg::DIV_STAGES-1];
  // a collapsed bracket takes the lower point
  assign wr_f = tl.rz  ? '0 : tti_pkg::wt_t'(qr);
  assign w0_f = tl.ez0 ? '0 : tti_pkg::wt_t'(q0);
  assign w1_f = tl.ez1 ? '0 : tti_pkg::wt_t'(q1);

  // ---------------- payload registers ----------------
  tti_pkg::prod_t sum0_g, sum1_g, sum_i;

  assign sum0_g = s6_q.pa0 + s6_q.pb0;
  assign sum1_g = s6_q.pa1 + s6_q.pb1;
  assign sum_i  = s8_q.pr0 + s8_q.pr1;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it1_q.cmd <= in_i.cmd;
      it1_q.ri  <= in_i.row_index;
      it1_q.pi  <= in_i.point_index;
      it1_q.ax  <= in_i.axis_value;
      it1_q.en  <= in_i.energy_value;
      it1_q.mo  <= in_i.mobility_value;

      s2_q.it    <= it1_q;
      s2_q.r0    <= r0_a;
      s2_q.r1    <= r1_a;
      s2_q.ac    <= ac_a;
      s2_q.ra_lo <= row_axis_q[r0_a];
      s2_q.ra_hi <= row_axis_q[r1_a];

      s3_q.it   <= s2_q.it;
      s3_q.r0   <= s2_q.r0;
      s3_q.r1   <= s2_q.r1;
      s3_q.ac   <= s2_q.ac;
      s3_q.rdx  <= s2_q.it.ax - s2_q.ra_lo;
      s3_q.rden <= s2_q.ra_hi - s2_q.ra_lo;
      epar_q    <= s2_q.r0[0];
      esame_q   <= s2_q.r0 == s2_q.r1;

      s4_q.it   <= s3_q.it;
      s4_q.r0   <= s3_q.r0;
      s4_q.r1   <= s3_q.r1;
      s4_q.ac   <= s3_q.ac;
      s4_q.ec   <= cl0_c || cl1_c;
      s4_q.rdx  <= s3_q.rdx;
      s4_q.rden <= s3_q.rden;
      s4_q.lo0  <= lo0_c;
      s4_q.hi0  <= hi0_c;
      s4_q.lo1  <= lo1_c;
      s4_q.hi1  <= hi1_c;
      s4_q.elo0 <= elo0_c;
      s4_q.ehi0 <= ehi0_c;
      s4_q.elo1 <= elo1_c;
      s4_q.ehi1 <= ehi1_c;

      s5_q.ac    <= s4_q.ac;
      s5_q.ec    <= s4_q.ec;
      s5_q.rz    <= s4_q.r0 == s4_q.r1;
      s5_q.ez0   <= s4_q.lo0 == s4_q.hi0;
      s5_q.ez1   <= s4_q.lo1 == s4_q.hi1;
      s5_q.same  <= s4_q.r0 == s4_q.r1;
      s5_q.r0p   <= s4_q.r0[0];
      s5_q.lo0p  <= s4_q.lo0[0];
      s5_q.hi0p  <= s4_q.hi0[0];
      s5_q.lo1p  <= s4_q.lo1[0];
      s5_q.hi1p  <= s4_q.hi1[0];
      s5_q.rdx   <= s4_q.rdx;
      s5_q.rden  <= s4_q.rden;
      s5_q.edx0  <= s4_q.it.en - s4_q.elo0;
      s5_q.eden0 <= s4_q.ehi0 - s4_q.elo0;
      s5_q.edx1  <= s4_q.it.en - s4_q.elo1;
      s5_q.eden1 <= s4_q.ehi1 - s4_q.elo1;

      tail_q[0] <= tail_e;
      for (int k = 1; k < tti_pkg::DIV_STAGES; k++) begin
        tail_q[k] <= tail_q[k-1];
      end

      s6_q.ac  <= tl.ac;
      s6_q.ec  <= tl.ec;
      s6_q.wr  <= wr_f;
      s6_q.pa0 <= tti_pkg::prod_t'(tti_pkg::W_ONE - w0_f) * tti_pkg::prod_t'(tl.ml0);
      s6_q.pb0 <= tti_pkg::prod_t'(w0_f) * tti_pkg::prod_t'(tl.mh0);
      s6_q.pa1 <= tti_pkg::prod_t'(tti_pkg::W_ONE - w1_f) * tti_pkg::prod_t'(tl.ml1);
      s6_q.pb1 <= tti_pkg::prod_t'(w1_f) * tti_pkg::prod_t'(tl.mh1);

      s7_q.ac  <= s6_q.ac;
      s7_q.ec  <= s6_q.ec;
      s7_q.wr  <= s6_q.wr;
      s7_q.mu0 <= sum0_g[tti_pkg::W_BITS +: tti_pkg::DATA_W];
      s7_q.mu1 <= sum1_g[tti_pkg::W_BITS +: tti_pkg::DATA_W];

      s8_q.ac  <= s7_q.ac;
      s8_q.ec  <= s7_q.ec;
      s8_q.pr0 <= tti_pkg::prod_t'(tti_pkg::W_ONE - s7_q.wr) * tti_pkg::prod_t'(s7_q.mu0);
      s8_q.pr1 <= tti_pkg::prod_t'(s7_q.wr) * tti_pkg::prod_t'(s7_q.mu1);

      mob_q <= sum_i[tti_pkg::W_BITS +: tti_pkg::DATA_W];
      ac_q  <= s8_q.ac;
      ec_q  <= s8_q.ec;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.mobility_out   = mob_q;
  assign out_o.axis_clamped   = ac_q;
  assign out_o.energy_clamped = ec_q;

endmodule

`default_nettype wire
